FILE: design/nmnp_pkg.sv
// ----------------------------------------------------------------------------
// nmnp_pkg
// Shared types and codes for the nearest mapped note picker.
// ----------------------------------------------------------------------------
package nmnp_pkg;

   localparam int NOTE_W   = 7;
   localparam int OFFSET_W = 8;
   localparam int CSR_W    = 7;

   localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_PICK  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_PICK_MODE     = 2'd0;
   localparam logic [1:0] CSR_TAPE_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_STRETCH_LIMIT = 2'd2;

   // pick modes
   localparam logic MODE_TAPE    = 1'b0;
   localparam logic MODE_STRETCH = 1'b1;

   localparam logic [CSR_W-1:0] TAPE_LIMIT_RST    = 7'd7;
   localparam logic [CSR_W-1:0] STRETCH_LIMIT_RST = 7'd48;

   typedef struct packed {
      logic             pick_mode;
      logic [CSR_W-1:0] tape_limit;
      logic [CSR_W-1:0] stretch_limit;
   } cfg_type;

   typedef struct packed {
      logic                       slot_found;
      logic [NOTE_W-1:0]          chosen_slot;
      logic signed [OFFSET_W-1:0] pitch_offset;
   } rsp_type;

endpackage

FILE: design/nmnp_slot_map.sv
// ----------------------------------------------------------------------------
// nmnp_slot_map
// One flag per note slot: set by a load, all cleared by reset or a clear
// word. Two read ports serve the lower and upper probes of the scan.
// ----------------------------------------------------------------------------
module nmnp_slot_map #(
   parameter int NUM_SLOTS = 128,
   parameter int AW        = $clog2(NUM_SLOTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_idx,
   input  logic          clr,
   input  logic [AW-1:0] rd_idx_a,
   input  logic [AW-1:0] rd_idx_b,
   output logic          rd_data_a,
   output logic          rd_data_b
);

   logic [NUM_SLOTS-1:0] map_ff;
   logic [NUM_SLOTS-1:0] map_in;

   always_comb begin
      map_in = map_ff;
      if (clr) begin
         map_in = '0;
      end else if (wr_en) begin
         map_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   // callers gate out-of-range indexes
   assign rd_data_a = map_ff[rd_idx_a];
   assign rd_data_b = map_ff[rd_idx_b];

endmodule

FILE: design/nmnp_scan_seq.sv
// ----------------------------------------------------------------------------
// nmnp_scan_seq
// Outward scan sequencer: one distance step per cycle, probing the slots
// below and above the note together, the lower one winning a tie, then forms the result word.
// ----------------------------------------------------------------------------
module nmnp_scan_seq #(
   parameter int NUM_SLOTS = 128,
   parameter int AW        = $clog2(NUM_SLOTS),
   parameter int DW        = $clog2(NUM_SLOTS + 128)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [nmnp_pkg::NOTE_W-1:0]     note,
   input  nmnp_pkg::cfg_type               cfg,
   output logic [AW-1:0]                   rd_idx_a,
   output logic [AW-1:0]                   rd_idx_b,
   input  logic                            rd_data_a,
   input  logic                            rd_data_b,
   output logic                            busy,
   output logic                            rsp_valid,
   output nmnp_pkg::rsp_type               rsp
);

   import nmnp_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   localparam logic [DW:0] SLOTS_W = (DW+1)'(NUM_SLOTS);

   state_type         state_ff;
   logic [NOTE_W-1:0] note_ff;
   logic [DW-1:0]     dist_ff;
   logic              hit_ff;
   logic              lower_ff;
   logic [NOTE_W-1:0] slot_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              lo_valid;
   logic [NOTE_W-1:0] lo_idx;
   logic [DW:0]       hi_sum;
   logic              hi_valid;
   logic              lo_hit;
   logic              hi_hit;
   logic              exhausted;

   logic              fin_found;
   logic [NOTE_W-1:0] fin_mag;
   rsp_type           rsp_in;

   // probe pair at the current distance
   always_comb begin
      lo_valid  = (dist_ff <= DW'(note_ff))
                  && ((DW+1)'(note_ff) - (DW+1)'(dist_ff) < SLOTS_W);
      lo_idx    = note_ff - dist_ff[NOTE_W-1:0];
      hi_sum    = (DW+1)'(note_ff) + (DW+1)'(dist_ff);
      hi_valid  = hi_sum < SLOTS_W;
      lo_hit    = lo_valid && rd_data_a;
      hi_hit    = hi_valid && rd_data_b;
      exhausted = (dist_ff > DW'(note_ff)) && !hi_valid;
   end

   assign rd_idx_a = AW'(lo_idx);
   assign rd_idx_b = AW'(hi_sum);

   // limit checks on the hit distance
   always_comb begin
      fin_found = hit_ff;
      fin_mag   = dist_ff[NOTE_W-1:0];
      if (cfg.pick_mode == MODE_STRETCH) begin
         if (dist_ff > DW'(cfg.stretch_limit)) begin
            fin_mag = cfg.stretch_limit;
         end
      end else if (dist_ff > DW'(cfg.tape_limit)) begin
         fin_found = 1'b0;
      end
      rsp_in = '0;
      if (fin_found) begin
         rsp_in.slot_found   = 1'b1;
         rsp_in.chosen_slot  = slot_ff;
         rsp_in.pitch_offset = lower_ff ? $signed({1'b0, fin_mag})
                                        : -$signed({1'b0, fin_mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  note_ff  <= note;
                  dist_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               priority if (lo_hit) begin
                  hit_ff   <= 1'b1;
                  lower_ff <= 1'b1;
                  slot_ff  <= lo_idx;
                  state_ff <= ST_FINISH;
               end else if (hi_hit) begin
                  hit_ff   <= 1'b1;
                  lower_ff <= 1'b0;
                  slot_ff  <= hi_sum[NOTE_W-1:0];
                  state_ff <= ST_FINISH;
               end else if (exhausted) begin
                  hit_ff   <= 1'b0;
                  lower_ff <= 1'b0;
                  slot_ff  <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  dist_ff <= dist_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_silence_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.slot_found) |->
         (rsp_ff.chosen_slot == '0 && rsp_ff.pitch_offset == '0))
      else $error("silent result carries a slot or offset");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("pick accepted but sequencer not busy");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (hi_sum <= SLOTS_W + (DW+1)'(NOTE_MAX)))
      else $error("scan ran past the end of the map");

endmodule

FILE: design/nearest_mapped_note_picker_unit.sv
// ----------------------------------------------------------------------------
// nearest_mapped_note_picker_unit
// Slot map with load and clear, and a nearest-loaded-slot picker with tape
// and stretch limits on the pitch offset.
// ----------------------------------------------------------------------------
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+------------------
//  request   | req_type, req_load_slot, req_requested_note  | start, busy
//  result    | rsp_slot_found, rsp_chosen_slot,             | rsp_strobe
//            | rsp_pitch_offset                             |
//  registers | csr_index, csr_wdata                         | csr_wr_en
//
//  Load and clear words finish at the accepting edge; busy never rises.
//  A pick scans outward from the accepting edge to distance d, d being the
//  distance to the chosen slot (up to max(128, NUM_SLOTS) on a miss), then
//  a finish state forms the result: the scan sequencer probes one distance
//  step per cycle. Busy falls with the strobe, so the next word can be
//  accepted at the edge that takes the result.
//  Reset clears the map and loads register defaults.
//  The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module nearest_mapped_note_picker_unit #(
   parameter int NUM_SLOTS = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_type,
   input  logic [6:0]                             req_load_slot,
   input  logic signed [8:0]                      req_requested_note,
   output logic                                   rsp_strobe,
   output logic                                   rsp_slot_found,
   output logic [nmnp_pkg::NOTE_W-1:0]            rsp_chosen_slot,
   output logic signed [nmnp_pkg::OFFSET_W-1:0]   rsp_pitch_offset,
   input  logic                                   csr_wr_en,
   input  logic [1:0]                             csr_index,
   input  logic [nmnp_pkg::CSR_W-1:0]             csr_wdata
);

   import nmnp_pkg::*;

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int DW = $clog2(NUM_SLOTS + 128);
   localparam logic [8:0] SLOTS_W = 9'(NUM_SLOTS);

   cfg_type           cfg_ff;
   logic              accept;
   logic              map_wr;
   logic              map_clr;
   logic              pick_start;
   logic [NOTE_W-1:0] note_clamped;
   logic [AW-1:0]     rd_idx_a;
   logic [AW-1:0]     rd_idx_b;
   logic              rd_data_a;
   logic              rd_data_b;
   logic              seq_busy;
   logic              rsp_valid;
   rsp_type           rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pick_mode     <= MODE_TAPE;
         cfg_ff.tape_limit    <= TAPE_LIMIT_RST;
         cfg_ff.stretch_limit <= STRETCH_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PICK_MODE:     cfg_ff.pick_mode     <= csr_wdata[0];
            CSR_TAPE_LIMIT:    cfg_ff.tape_limit    <= csr_wdata;
            CSR_STRETCH_LIMIT: cfg_ff.stretch_limit <= csr_wdata;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   assign busy       = seq_busy;
   assign accept     = start && !seq_busy;
   assign map_wr     = accept && (req_type == REQ_LOAD)
                       && ({2'b00, req_load_slot} < SLOTS_W);
   assign map_clr    = accept && (req_type == REQ_CLEAR);
   assign pick_start = accept && (req_type == REQ_PICK);

   // clamp the note to 0..127
   always_comb begin
      if (req_requested_note[8]) begin
         note_clamped = '0;
      end else if (req_requested_note[7]) begin
         note_clamped = NOTE_MAX;
      end else begin
         note_clamped = req_requested_note[6:0];
      end
   end

   nmnp_slot_map #(
      .NUM_SLOTS (NUM_SLOTS),
      .AW        (AW)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (map_wr),
      .wr_idx    (AW'(req_load_slot)),
      .clr       (map_clr),
      .rd_idx_a  (rd_idx_a),
      .rd_idx_b  (rd_idx_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   nmnp_scan_seq #(
      .NUM_SLOTS (NUM_SLOTS),
      .AW        (AW),
      .DW        (DW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (pick_start),
      .note      (note_clamped),
      .cfg       (cfg_ff),
      .rd_idx_a  (rd_idx_a),
      .rd_idx_b  (rd_idx_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .busy      (seq_busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_strobe       = rsp_valid;
   assign rsp_slot_found   = rsp.slot_found;
   assign rsp_chosen_slot  = rsp.chosen_slot;
   assign rsp_pitch_offset = rsp.pitch_offset;

endmodule
